@@ rtl/cdq_pkg.sv @@
// Shared types, constants and index helpers for the circular deque.
// No dependencies; every other file of the block but cdq_ram refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

   // Built ring depth, the widths that follow from it and the data width.
   localparam int DEPTH  = 1024;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   // Configuration register and bus widths.
   localparam int CAP_W    = 11;
   localparam int APB_W    = 32;
   localparam int PADDR_W  = 3;
   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   localparam logic signed [DATA_W-1:0] EMPTY_WORD = '1;

   // Register index, taken from the word address bit of paddr.
   typedef enum logic {
      REG_CAPACITY = 1'b0,
      REG_NONE     = 1'b1
   } reg_idx_type;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_QUERY      = 3'd4
   } op_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic             clear;
      logic [CNT_W-1:0] cap;
   } cfg_type;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
      logic [CNT_W:0] nxt;
      nxt = (CNT_W+1)'(idx) + 1'b1;
      if (nxt >= (CNT_W+1)'(cap)) begin
         return '0;
      end
      return IDX_W'(nxt);
   endfunction

   function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
      if (idx == '0 || CNT_W'(idx) >= cap) begin
         return IDX_W'(cap - 1'b1);
      end
      return idx - 1'b1;
   endfunction

endpackage

`default_nettype wire

@@ rtl/cdq_if.sv @@
// Valid/ready channel interfaces for the circular deque: request and response.
// Depends on cdq_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

interface cdq_req_if;
   logic                              valid;
   logic                              ready;
   logic [2:0]                        operation;
   logic signed [cdq_pkg::DATA_W-1:0] value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface cdq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              ok;
   logic signed [cdq_pkg::DATA_W-1:0] front_value;
   logic signed [cdq_pkg::DATA_W-1:0] rear_value;
   logic                              is_empty;
   logic                              is_full;

   modport source (output valid, output ok, output front_value, output rear_value,
                   output is_empty, output is_full, input ready);
   modport sink   (input valid, input ok, input front_value, input rear_value,
                   input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

@@ rtl/cdq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cdq_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/cdq_csr.sv @@
// APB-style register port holding the capacity register of the deque.
// Depends on cdq_pkg; produces the effective capacity and a clear pulse.
`timescale 1ns / 1ps
`default_nettype none

module cdq_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [cdq_pkg::PADDR_W-1:0]   csr_paddr,
   input  wire logic [cdq_pkg::APB_W-1:0]     csr_pwdata,
   output      logic [cdq_pkg::APB_W-1:0]     csr_prdata,
   output      logic                          csr_pready,
   output      cdq_pkg::cfg_type              cfg
);

   logic [cdq_pkg::CAP_W-1:0] cap_ff;
   logic [cdq_pkg::CAP_W-1:0] cap_in;
   cdq_pkg::reg_idx_type      reg_idx;
   logic                      wr_cap;
   logic [31:0]               cap_wide;

   assign csr_pready = 1'b1;
   assign reg_idx    = cdq_pkg::reg_idx_type'(csr_paddr[2]);
   assign wr_cap     = csr_psel && csr_penable && csr_pwrite
                       && (reg_idx == cdq_pkg::REG_CAPACITY);
   assign cap_in     = wr_cap ? csr_pwdata[cdq_pkg::CAP_W-1:0] : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= cdq_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         cdq_pkg::REG_CAPACITY: csr_prdata = cdq_pkg::APB_W'(cap_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // Zero reads as one entry; anything beyond the built depth saturates.
   assign cap_wide = 32'(cap_ff);

   always_comb begin
      if (cap_wide == 32'd0) begin
         cfg.cap = cdq_pkg::CNT_W'(1);
      end else if (cap_wide > 32'(cdq_pkg::DEPTH)) begin
         cfg.cap = cdq_pkg::CNT_W'(cdq_pkg::DEPTH);
      end else begin
         cfg.cap = cdq_pkg::CNT_W'(cap_wide);
      end
      cfg.clear = wr_cap;
   end

endmodule

`default_nettype wire

@@ rtl/circular_deque.sv @@
// Top level of the circular deque: operation decode, index and occupancy state.
// Depends on cdq_pkg, cdq_if (channels), cdq_ram (ring store) and cdq_csr.
`timescale 1ns / 1ps
`default_nettype none

// The block is a double-ended queue of 32-bit words kept in a ring store of
// cdq_pkg::DEPTH entries, of which the capacity register selects how many are
// used. Every request transfer carries one operation (push front, push rear,
// pop front, pop rear or query) and yields exactly one response transfer with
// the ok flag, the front and rear words after the operation (all ones when the
// deque is empty) and the empty and full flags. A refused push or pop changes
// nothing. The block takes one request per cycle while the response side keeps
// up; a response passes the waiting-item register, covering the registered read
// of the ring memory that a pop needs for the new end word, and then the output
// register. Writing the capacity register empties the deque and must only be
// done while no request is outstanding. There is no clearing pass after reset:
// the deque starts empty and only written entries are ever read.
module circular_deque (
   input  wire logic                          clock,
   input  wire logic                          reset,
   cdq_req_if.sink                            req_chan,
   cdq_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [cdq_pkg::PADDR_W-1:0]   csr_paddr,
   input  wire logic [cdq_pkg::APB_W-1:0]     csr_pwdata,
   output      logic [cdq_pkg::APB_W-1:0]     csr_prdata,
   output      logic                          csr_pready
);

   localparam int IDX_W  = cdq_pkg::IDX_W;
   localparam int CNT_W  = cdq_pkg::CNT_W;
   localparam int DATA_W = cdq_pkg::DATA_W;

   cdq_pkg::cfg_type cfg;

   // Deque state.
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [IDX_W-1:0]         tail_ff, tail_in;
   logic [CNT_W-1:0]         occ_ff, occ_in;
   // Copies of the words at head and tail. A pop refreshes one of them from
   // the memory read that it issues; pend_* marks that the copy arrives next.
   logic signed [DATA_W-1:0] front_ff, front_in;
   logic signed [DATA_W-1:0] rear_ff, rear_in;
   logic                     pend_front_ff, pend_front_in;
   logic                     pend_rear_ff, pend_rear_in;

   // Accepted item, waiting for the memory read of a pop and for the output register.
   logic                     busy_ff, busy_in;
   logic                     res_ok_ff, res_ok_in;
   logic                     res_empty_ff, res_empty_in;
   logic                     res_full_ff, res_full_in;

   // Response output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ok_ff, rsp_ok_in;
   logic signed [DATA_W-1:0] rsp_front_ff, rsp_front_in;
   logic signed [DATA_W-1:0] rsp_rear_ff, rsp_rear_in;
   logic                     rsp_empty_ff, rsp_empty_in;
   logic                     rsp_full_ff, rsp_full_in;

   // Memory ports.
   logic                     wr_en, rd_en;
   logic [IDX_W-1:0]         wr_addr, rd_addr;
   logic [DATA_W-1:0]        rd_data;

   logic                     advance;
   logic                     accept;
   logic                     ok_c;
   logic signed [DATA_W-1:0] cur_front, cur_rear;
   cdq_pkg::op_type          op;

   cdq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cdq_ram #(
      .DEPTH (cdq_pkg::DEPTH),
      .WIDTH (DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The end words as they stand now, with the read of the previous pop
   // forwarded straight from the memory output.
   assign cur_front = pend_front_ff ? $signed(rd_data) : front_ff;
   assign cur_rear  = pend_rear_ff  ? $signed(rd_data) : rear_ff;

   // The waiting item moves into the output register when that is free or
   // being emptied in this cycle; a new request may enter in the same cycle.
   assign advance        = busy_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !busy_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign op             = cdq_pkg::op_type'(req_chan.operation);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      front_in      = cur_front;
      rear_in       = cur_rear;
      pend_front_in = 1'b0;
      pend_rear_in  = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      ok_c          = 1'b1;

      if (accept) begin
         unique case (op) inside
            cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
               if (occ_ff >= cfg.cap) begin
                  ok_c = 1'b0;
               end else begin
                  // A push into an empty deque restarts both ends at entry zero.
                  if (occ_ff == '0) begin
                     head_in  = '0;
                     tail_in  = '0;
                     wr_addr  = '0;
                     front_in = req_chan.value;
                     rear_in  = req_chan.value;
                  end else if (op == cdq_pkg::OP_PUSH_FRONT) begin
                     head_in  = cdq_pkg::wrap_dec(head_ff, cfg.cap);
                     wr_addr  = head_in;
                     front_in = req_chan.value;
                  end else begin
                     tail_in  = cdq_pkg::wrap_inc(tail_ff, cfg.cap);
                     wr_addr  = tail_in;
                     rear_in  = req_chan.value;
                  end
                  wr_en  = 1'b1;
                  occ_in = occ_ff + 1'b1;
               end
            end
            cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR: begin
               if (occ_ff == '0) begin
                  ok_c = 1'b0;
               end else if (occ_ff == CNT_W'(1)) begin
                  head_in = '0;
                  tail_in = '0;
                  occ_in  = '0;
               end else begin
                  if (op == cdq_pkg::OP_POP_FRONT) begin
                     head_in       = cdq_pkg::wrap_inc(head_ff, cfg.cap);
                     rd_addr       = head_in;
                     pend_front_in = 1'b1;
                  end else begin
                     tail_in      = cdq_pkg::wrap_dec(tail_ff, cfg.cap);
                     rd_addr      = tail_in;
                     pend_rear_in = 1'b1;
                  end
                  rd_en  = 1'b1;
                  occ_in = occ_ff - 1'b1;
               end
            end
            default: begin
               // Query and the unused codes leave everything as it is.
            end
         endcase
      end

      // A capacity write empties the deque; the user must only write it while idle, which the block does not enforce.
      if (cfg.clear) begin
         head_in = '0;
         tail_in = '0;
         occ_in  = '0;
      end
   end

   always_comb begin
      busy_in      = accept ? 1'b1 : (advance ? 1'b0 : busy_ff);
      res_ok_in    = accept ? ok_c : res_ok_ff;
      res_empty_in = accept ? (occ_in == '0) : res_empty_ff;
      res_full_in  = accept ? (occ_in >= cfg.cap) : res_full_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_front_in = rsp_front_ff;
      rsp_rear_in  = rsp_rear_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_full_in  = rsp_full_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = res_ok_ff;
         rsp_front_in = res_empty_ff ? cdq_pkg::EMPTY_WORD : cur_front;
         rsp_rear_in  = res_empty_ff ? cdq_pkg::EMPTY_WORD : cur_rear;
         rsp_empty_in = res_empty_ff;
         rsp_full_in  = res_full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         occ_ff        <= '0;
         pend_front_ff <= 1'b0;
         pend_rear_ff  <= 1'b0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         occ_ff        <= occ_in;
         pend_front_ff <= pend_front_in;
         pend_rear_ff  <= pend_rear_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff     <= front_in;
      rear_ff      <= rear_in;
      res_ok_ff    <= res_ok_in;
      res_empty_ff <= res_empty_in;
      res_full_ff  <= res_full_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_front_ff <= rsp_front_in;
      rsp_rear_ff  <= rsp_rear_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.ok          = rsp_ok_ff;
   assign rsp_chan.front_value = rsp_front_ff;
   assign rsp_chan.rear_value  = rsp_rear_ff;
   assign rsp_chan.is_empty    = rsp_empty_ff;
   assign rsp_chan.is_full     = rsp_full_ff;

   // The deque never holds more words than the capacity in use.
   assert property (@(posedge clock) disable iff (reset) occ_ff <= cfg.cap)
      else $error("occupancy exceeds capacity");

   // With a single word held, front and rear point at the same entry.
   assert property (@(posedge clock) disable iff (reset)
      occ_ff == CNT_W'(1) |-> head_ff == tail_ff)
      else $error("single word but head and tail differ");

   // A refused operation leaves the occupancy untouched.
   assert property (@(posedge clock) disable iff (reset)
      accept && !ok_c && !cfg.clear |=> $stable(occ_ff))
      else $error("refused operation changed occupancy");

   // A memory read result is only pending for the item that waits for it, and for one end at a time.
   assert property (@(posedge clock) disable iff (reset)
      (pend_front_ff || pend_rear_ff) |-> busy_ff && !(pend_front_ff && pend_rear_ff))
      else $error("pending read without a waiting item");

   // A response never reports empty and full together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_empty_ff && rsp_full_ff))
      else $error("response both empty and full");

endmodule

`default_nettype wire
